FILE: sv/rwl_pkg.sv
// rwl_pkg: shared types and constants for the reader-writer lock manager
// no dependencies; imported by rwl_front, rwl_back and the top level
`timescale 1ns / 1ps

package rwl_pkg;

  localparam int unsigned TID_W     = 8;
  localparam int unsigned READERS_W = 8;
  localparam logic [READERS_W-1:0] READERS_MAX = 8'd255;

  typedef enum logic [1:0] {
    REQ_RD_LOCK   = 2'd0,
    REQ_WR_LOCK   = 2'd1,
    REQ_RD_UNLOCK = 2'd2,
    REQ_WR_UNLOCK = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_QUEUED = 2'd1,
    STAT_ERROR  = 2'd2,
    STAT_FULL   = 2'd3
  } status_e;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_WAKE   = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    BS_EXEC,
    BS_DRAIN_WR,
    BS_DRAIN_RD
  } back_state_e;

  typedef struct packed {
    req_e             req;
    logic [TID_W-1:0] tid;
  } rwl_item_t;

endpackage

FILE: sv/rwl_front.sv
// rwl_front: request intake, decodes the request kind and queues items
// depends on rwl_pkg
`timescale 1ns / 1ps

module rwl_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        req_type_i,
  input  logic [7:0]        thread_id_i,
  output logic              item_valid_o,
  output rwl_pkg::rwl_item_t item_o,
  input  logic              item_pop_i
);
  import rwl_pkg::*;

  rwl_item_t  buf_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  rwl_item_t  new_item;

  // classify the raw request code
  always_comb begin
    new_item.req = req_e'(req_type_i);
    new_item.tid = thread_id_i;
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = buf_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_pop_i && item_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

FILE: sv/rwl_back.sv
// rwl_back: lock state, wait stacks, result register and wake sequencer
// depends on rwl_pkg
`timescale 1ns / 1ps

module rwl_back #(
  parameter int unsigned WAIT_DEPTH     = 16,
  parameter int unsigned THREAD_ID_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  rwl_pkg::rwl_item_t item_i,
  output logic               item_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               result_kind_o,
  output logic [1:0]         status_o,
  output logic [7:0]         woken_thread_o,
  output logic               last_o
);
  import rwl_pkg::*;

  localparam int unsigned CntW   = $clog2(WAIT_DEPTH + 1);
  localparam int unsigned IdxW   = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int unsigned StoreW = (THREAD_ID_BITS < TID_W) ? THREAD_ID_BITS : TID_W;
  localparam logic [CntW-1:0] DepthC = CntW'(WAIT_DEPTH);

  back_state_e state_q, state_d;

  logic                 busy_q, busy_d;
  logic                 wact_q, wact_d;
  logic [READERS_W-1:0] readers_q, readers_d;
  logic [CntW-1:0]      wcnt_q, wcnt_d, wcnt_m1;
  logic [CntW-1:0]      rcnt_q, rcnt_d, rcnt_m1;
  logic [StoreW-1:0]    wstk_q [WAIT_DEPTH];
  logic [StoreW-1:0]    rstk_q [WAIT_DEPTH];

  logic                 out_valid_q, out_valid_d;
  logic                 kind_q, kind_d;
  logic [1:0]           status_q, status_d;
  logic [TID_W-1:0]     woken_q, woken_d;
  logic                 last_q, last_d;

  logic                 out_free, exec_go, wake_go;
  logic                 release_c, push_w, push_r;
  status_e              stat_c;
  logic [StoreW-1:0]    who;

  assign out_free = !out_valid_q || out_ready_i;
  assign exec_go  = (state_q == BS_EXEC) && item_valid_i && out_free;
  assign wake_go  = (state_q != BS_EXEC) && out_free;
  assign item_pop_o = exec_go;
  assign who      = item_i.tid[StoreW-1:0];
  assign wcnt_m1  = wcnt_q - 1'b1;
  assign rcnt_m1  = rcnt_q - 1'b1;

  // request decision, writer preference
  always_comb begin
    busy_d    = busy_q;
    wact_d    = wact_q;
    readers_d = readers_q;
    stat_c    = STAT_ERROR;
    release_c = 1'b0;
    push_w    = 1'b0;
    push_r    = 1'b0;
    unique case (item_i.req)
      REQ_RD_LOCK: begin
        if (!busy_q || (!wact_q && wcnt_q == '0)) begin
          if (readers_q != READERS_MAX) begin
            busy_d    = 1'b1;
            readers_d = readers_q + 1'b1;
            stat_c    = STAT_OK;
          end
        end else if (rcnt_q >= DepthC) begin
          stat_c = STAT_FULL;
        end else begin
          push_r = 1'b1;
          stat_c = STAT_QUEUED;
        end
      end
      REQ_WR_LOCK: begin
        if (!busy_q) begin
          busy_d = 1'b1;
          wact_d = 1'b1;
          stat_c = STAT_OK;
        end else if (wact_q || readers_q != '0) begin
          if (wcnt_q >= DepthC) begin
            stat_c = STAT_FULL;
          end else begin
            push_w = 1'b1;
            stat_c = STAT_QUEUED;
          end
        end
      end
      REQ_RD_UNLOCK: begin
        if (busy_q && readers_q != '0 && !wact_q) begin
          readers_d = readers_q - 1'b1;
          stat_c    = STAT_OK;
          if (readers_q == READERS_W'(1)) begin
            busy_d    = 1'b0;
            release_c = 1'b1;
          end
        end
      end
      REQ_WR_UNLOCK: begin
        if (busy_q && wact_q) begin
          busy_d    = 1'b0;
          wact_d    = 1'b0;
          release_c = 1'b1;
          stat_c    = STAT_OK;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_EXEC: begin
        if (exec_go && release_c) begin
          if (wcnt_q != '0) begin
            state_d = BS_DRAIN_WR;
          end else if (rcnt_q != '0) begin
            state_d = BS_DRAIN_RD;
          end
        end
      end
      BS_DRAIN_WR: begin
        if (wake_go && wcnt_m1 == '0) begin
          state_d = (rcnt_q != '0) ? BS_DRAIN_RD : BS_EXEC;
        end
      end
      BS_DRAIN_RD: begin
        if (wake_go && rcnt_m1 == '0) begin
          state_d = BS_EXEC;
        end
      end
      default: state_d = BS_EXEC;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    wcnt_d      = wcnt_q;
    rcnt_d      = rcnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    status_d    = status_q;
    woken_d     = woken_q;
    last_d      = last_q;
    unique case (state_q)
      BS_EXEC: begin
        if (exec_go) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_STATUS;
          status_d    = stat_c;
          woken_d     = '0;
          last_d      = !(release_c && (wcnt_q != '0 || rcnt_q != '0));
          if (push_w) wcnt_d = wcnt_q + 1'b1;
          if (push_r) rcnt_d = rcnt_q + 1'b1;
        end
      end
      BS_DRAIN_WR: begin
        if (wake_go) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_WAKE;
          status_d    = STAT_OK;
          woken_d     = TID_W'(wstk_q[wcnt_m1[IdxW-1:0]]);
          last_d      = (wcnt_m1 == '0) && (rcnt_q == '0);
          wcnt_d      = wcnt_m1;
        end
      end
      BS_DRAIN_RD: begin
        if (wake_go) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_WAKE;
          status_d    = STAT_OK;
          woken_d     = TID_W'(rstk_q[rcnt_m1[IdxW-1:0]]);
          last_d      = (rcnt_m1 == '0);
          rcnt_d      = rcnt_m1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_EXEC;
      busy_q      <= 1'b0;
      wact_q      <= 1'b0;
      readers_q   <= '0;
      wcnt_q      <= '0;
      rcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wcnt_q      <= wcnt_d;
      rcnt_q      <= rcnt_d;
      out_valid_q <= out_valid_d;
      if (exec_go) begin
        busy_q    <= busy_d;
        wact_q    <= wact_d;
        readers_q <= readers_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    status_q <= status_d;
    woken_q  <= woken_d;
    last_q   <= last_d;
    if (exec_go && push_w) wstk_q[wcnt_q[IdxW-1:0]] <= who;
    if (exec_go && push_r) rstk_q[rcnt_q[IdxW-1:0]] <= who;
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign status_o       = status_q;
  assign woken_thread_o = woken_q;
  assign last_o         = last_q;

`ifndef SYNTHESIS
  a_wcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wcnt_q <= DepthC && rcnt_q <= DepthC)
    else $error("wait count beyond stack depth");

  a_writer_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wact_q |-> (busy_q && readers_q == '0))
    else $error("writer active alongside readers or with lock free");

  a_readers_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (readers_q != '0) |-> (busy_q && !wact_q))
    else $error("readers active without a busy read-held lock");

  a_drain_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != BS_EXEC) |-> (!busy_q && !item_pop_o))
    else $error("lock taken or item popped while waking waiters");

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == BS_DRAIN_WR && wcnt_q == '0) ||
     (state_q == BS_DRAIN_RD && rcnt_q == '0)) |-> 1'b0)
    else $error("waking from an empty wait stack");
`endif

endmodule

FILE: sv/reader_writer_lock_manager_core.sv
// reader_writer_lock_manager_core: top level of the reader-writer lock manager
// depends on rwl_pkg, rwl_front and rwl_back
`timescale 1ns / 1ps

// Reader-writer lock manager with writer preference. Each request transfer
// carries a request kind (read lock, write lock, read unlock, write unlock)
// and a thread id. Every request yields one status result first; an unlock
// that frees the lock then yields one wake notice per waiting thread, all
// waiting writers first and then all waiting readers, each wait stack taken
// from its top (last queued, first woken). The final result of a request has
// last_o set. Woken threads must issue their request again. A lock request
// whose wait stack is full reports queue full and is dropped; mismatched
// unlocks and reader count overflow report an error and change nothing.
// Each status result and each wake notice is held in the back end's single
// result register, fed by the wake sequencer. A two-entry input queue lets
// requests arrive while wakes drain, and the result register holds each
// result until the consumer takes it, so the back end stalls while the
// consumer stalls. A request's status passes through the input queue and
// then the result register on its way to the outputs. Wait stacks hold up
// to WAIT_DEPTH threads each and keep the low THREAD_ID_BITS bits of the
// id, at most TID_W bits.
module reader_writer_lock_manager_core #(
  parameter int unsigned WAIT_DEPTH     = 16,
  parameter int unsigned THREAD_ID_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // request channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] thread_id_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       result_kind_o,
  output logic [1:0] status_o,
  output logic [7:0] woken_thread_o,
  output logic       last_o
);
  import rwl_pkg::*;

  // queued, decoded requests between front and back
  logic      item_valid;
  logic      item_pop;
  rwl_item_t item;

  // front: accepts request transfers and decodes them into the queue
  rwl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .thread_id_i  (thread_id_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // back: lock state, wait stacks, status and wake sequencing
  rwl_back #(
    .WAIT_DEPTH     (WAIT_DEPTH),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .item_i         (item),
    .item_pop_o     (item_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .status_o       (status_o),
    .woken_thread_o (woken_thread_o),
    .last_o         (last_o)
  );

endmodule
